>>> sv/histogram_3d_bin_accumulate_assert.svh
// assertion macros used by the accumulator sequencer
`ifndef HISTOGRAM_3D_BIN_ACCUMULATE_ASSERT_SVH
`define HISTOGRAM_3D_BIN_ACCUMULATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define H3BA_ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");
// next-cycle implication
`define H3BA_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");
`else
`define H3BA_ASSERT_IMPLY(lbl, pre, post)
`define H3BA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> sv/h3ba_pkg.sv
package h3ba_pkg;

	localparam int CFG_W     = 32;
	localparam int COORD_W   = 32;
	localparam int ENERGY_W  = 32;
	localparam int CONTENT_W = 48;
	localparam int BIN_W     = 4;
	localparam int REQ_W     = 2;
	localparam int IDX_W     = 3;
	localparam int ABS_W     = 32;
	localparam int NUM_W     = 42;
	localparam int QB_W      = 8;
	localparam int STEP_W    = 3;

	// request codes
	localparam logic [REQ_W-1:0] REQ_FILL  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_COORD = 2'd1;
	localparam logic [REQ_W-1:0] REQ_BIN   = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] CFG_X_LOW  = 3'd0;
	localparam logic [IDX_W-1:0] CFG_X_HIGH = 3'd1;
	localparam logic [IDX_W-1:0] CFG_Y_LOW  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_Y_HIGH = 3'd3;
	localparam logic [IDX_W-1:0] CFG_Z_LOW  = 3'd4;
	localparam logic [IDX_W-1:0] CFG_Z_HIGH = 3'd5;

	localparam logic signed [CFG_W-1:0] LOW_RST  = 32'sd0;
	localparam logic signed [CFG_W-1:0] HIGH_RST = 32'sd1048576;

	localparam logic [CONTENT_W-1:0] CONTENT_MAX = '1;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [STEP_W-1:0] STEP_TOP = 3'(QB_W - 1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_PREP,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_ADDR,
		ST_RD,
		ST_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              load;
		logic              idx;
		logic              prep;
		logic              mul;
		logic              cmp;
		logic              div;
		logic [1:0]        axis;
		logic [STEP_W-1:0] step;
		logic              addr;
		logic              rd;
		logic              upd;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic go_div;
		logic bin_req;
	} status_t;

endpackage

>>> sv/h3ba_ctrl.sv
`include "histogram_3d_bin_accumulate_assert.svh"

module h3ba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  h3ba_pkg::status_t status,
	output h3ba_pkg::cmd_t    cmd
);

	h3ba_pkg::state_t state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic [h3ba_pkg::STEP_W-1:0] step_q, step_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == h3ba_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		axis_d = axis_q;
		step_d = step_q;
		unique case (state_q)
			h3ba_pkg::ST_CLEAR: begin
				if (status.clr_last) state_d = h3ba_pkg::ST_IDLE;
			end
			h3ba_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = h3ba_pkg::ST_START;
					axis_d = h3ba_pkg::AXIS_X;
				end
			end
			h3ba_pkg::ST_START: begin
				state_d = status.bin_req ? h3ba_pkg::ST_ADDR : h3ba_pkg::ST_MUL;
			end
			h3ba_pkg::ST_PREP: state_d = h3ba_pkg::ST_MUL;
			h3ba_pkg::ST_MUL: state_d = h3ba_pkg::ST_CMP;
			h3ba_pkg::ST_CMP: begin
				if (status.go_div) begin
					state_d = h3ba_pkg::ST_DIV;
					step_d = h3ba_pkg::STEP_TOP;
				end else if (axis_q == h3ba_pkg::AXIS_Z) begin
					state_d = h3ba_pkg::ST_ADDR;
				end else begin
					state_d = h3ba_pkg::ST_PREP;
					axis_d = axis_q + 2'd1;
				end
			end
			h3ba_pkg::ST_DIV: begin
				if (step_q != '0) begin
					step_d = step_q - 1'b1;
				end else if (axis_q == h3ba_pkg::AXIS_Z) begin
					state_d = h3ba_pkg::ST_ADDR;
				end else begin
					state_d = h3ba_pkg::ST_PREP;
					axis_d = axis_q + 2'd1;
				end
			end
			h3ba_pkg::ST_ADDR: state_d = h3ba_pkg::ST_RD;
			h3ba_pkg::ST_RD: state_d = h3ba_pkg::ST_UPD;
			h3ba_pkg::ST_UPD: state_d = h3ba_pkg::ST_DONE;
			h3ba_pkg::ST_DONE: begin
				if (out_free) state_d = h3ba_pkg::ST_IDLE;
			end
			default: state_d = h3ba_pkg::ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		cmd.step = step_q;
		unique case (state_q)
			h3ba_pkg::ST_CLEAR: cmd.clear = 1'b1;
			h3ba_pkg::ST_IDLE: cmd.load = in_valid;
			h3ba_pkg::ST_START: begin
				cmd.idx = status.bin_req;
				cmd.prep = !status.bin_req;
			end
			h3ba_pkg::ST_PREP: cmd.prep = 1'b1;
			h3ba_pkg::ST_MUL: cmd.mul = 1'b1;
			h3ba_pkg::ST_CMP: cmd.cmp = 1'b1;
			h3ba_pkg::ST_DIV: cmd.div = 1'b1;
			h3ba_pkg::ST_ADDR: cmd.addr = 1'b1;
			h3ba_pkg::ST_RD: cmd.rd = 1'b1;
			h3ba_pkg::ST_UPD: cmd.upd = 1'b1;
			h3ba_pkg::ST_DONE: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= h3ba_pkg::ST_CLEAR;
			axis_q <= h3ba_pkg::AXIS_X;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			axis_q <= axis_d;
			step_q <= step_d;
		end
	end

	// output word pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`H3BA_ASSERT_IMPLY(a_axis_legal, 1'b1, (axis_q == h3ba_pkg::AXIS_X) || (axis_q == h3ba_pkg::AXIS_Y) || (axis_q == h3ba_pkg::AXIS_Z))
	`H3BA_ASSERT_NEXT(a_div_holds, (state_q == h3ba_pkg::ST_DIV) && (step_q != '0), state_q == h3ba_pkg::ST_DIV)
	`H3BA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
	`H3BA_ASSERT_NEXT(a_done_shows, (state_q == h3ba_pkg::ST_DONE) && out_free, out_valid_q)

endmodule

>>> sv/h3ba_dp.sv
module h3ba_dp #(
	parameter int X_BINS = 16,
	parameter int Y_BINS = 16,
	parameter int Z_BINS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  h3ba_pkg::cmd_t                         cmd,
	output h3ba_pkg::status_t                      status,
	input  logic                                   cfg_we,
	input  logic [h3ba_pkg::IDX_W-1:0]             cfg_index,
	input  logic [h3ba_pkg::CFG_W-1:0]             cfg_data,
	input  logic [h3ba_pkg::REQ_W-1:0]             req_type,
	input  logic signed [h3ba_pkg::COORD_W-1:0]    coord_x,
	input  logic signed [h3ba_pkg::COORD_W-1:0]    coord_y,
	input  logic signed [h3ba_pkg::COORD_W-1:0]    coord_z,
	input  logic [h3ba_pkg::ENERGY_W-1:0]          energy,
	input  logic [h3ba_pkg::BIN_W-1:0]             bin_x,
	input  logic [h3ba_pkg::BIN_W-1:0]             bin_y,
	input  logic [h3ba_pkg::BIN_W-1:0]             bin_z,
	output logic [h3ba_pkg::CONTENT_W-1:0]         content,
	output logic [h3ba_pkg::BIN_W-1:0]             bin_x_out,
	output logic [h3ba_pkg::BIN_W-1:0]             bin_y_out,
	output logic [h3ba_pkg::BIN_W-1:0]             bin_z_out,
	output logic                                   clamped
);

	localparam int DEPTH = X_BINS * Y_BINS * Z_BINS;
	localparam int AW = $clog2(DEPTH);
	localparam int NW = h3ba_pkg::NUM_W;
	localparam int QW = h3ba_pkg::QB_W;
	localparam int CW = h3ba_pkg::CONTENT_W;
	localparam logic [QW-1:0] X_TOP = QW'(X_BINS - 1);
	localparam logic [QW-1:0] Y_TOP = QW'(Y_BINS - 1);
	localparam logic [QW-1:0] Z_TOP = QW'(Z_BINS - 1);
	localparam logic [QW:0] X_CNT = (QW+1)'(X_BINS);
	localparam logic [QW:0] Y_CNT = (QW+1)'(Y_BINS);
	localparam logic [QW:0] Z_CNT = (QW+1)'(Z_BINS);

	// range registers
	logic signed [h3ba_pkg::CFG_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q, z_low_q, z_high_q;

	// captured request
	logic [h3ba_pkg::REQ_W-1:0] req_q;
	logic signed [h3ba_pkg::COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [h3ba_pkg::ENERGY_W-1:0] energy_q;
	logic [h3ba_pkg::BIN_W-1:0] ix_q, iy_q, iz_q;

	// axis mapping
	logic [h3ba_pkg::ABS_W-1:0] an_q, ad_q;
	logic skip_q;
	logic [NW-1:0] n_q, lim_q;
	logic [QW-1:0] quo_q;
	logic [QW-1:0] bx_q, by_q, bz_q;
	logic clamp_q;

	// memory side
	logic [AW-1:0] addr_q, clr_q;
	logic [CW-1:0] rd_q, res_q;
	logic [CW-1:0] mem [DEPTH];
	logic [CW-1:0] content_q;
	logic [h3ba_pkg::BIN_W-1:0] bxo_q, byo_q, bzo_q;
	logic clamped_q;

	logic signed [h3ba_pkg::COORD_W-1:0] sel_c, sel_l, sel_h;
	logic [QW-1:0] sel_top;
	logic [QW:0] sel_cnt;
	logic signed [h3ba_pkg::COORD_W:0] num_d, den_d;
	logic [h3ba_pkg::COORD_W:0] an_d, ad_d;
	logic [NW-1:0] dsh_d;
	logic ge_d;
	logic [QW-1:0] quo_d;
	logic [CW:0] sum_d;
	logic [CW-1:0] sat_d;
	logic we_d;
	logic [AW-1:0] wa_d;
	logic [CW-1:0] wd_d;
	logic [AW-1:0] addr_d;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q <= h3ba_pkg::LOW_RST;
			x_high_q <= h3ba_pkg::HIGH_RST;
			y_low_q <= h3ba_pkg::LOW_RST;
			y_high_q <= h3ba_pkg::HIGH_RST;
			z_low_q <= h3ba_pkg::LOW_RST;
			z_high_q <= h3ba_pkg::HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				h3ba_pkg::CFG_X_LOW: x_low_q <= cfg_data;
				h3ba_pkg::CFG_X_HIGH: x_high_q <= cfg_data;
				h3ba_pkg::CFG_Y_LOW: y_low_q <= cfg_data;
				h3ba_pkg::CFG_Y_HIGH: y_high_q <= cfg_data;
				h3ba_pkg::CFG_Z_LOW: z_low_q <= cfg_data;
				h3ba_pkg::CFG_Z_HIGH: z_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// axis select
	always_comb begin
		unique case (cmd.axis)
			h3ba_pkg::AXIS_X: begin
				sel_c = cx_q; sel_l = x_low_q; sel_h = x_high_q;
				sel_top = X_TOP; sel_cnt = X_CNT;
			end
			h3ba_pkg::AXIS_Y: begin
				sel_c = cy_q; sel_l = y_low_q; sel_h = y_high_q;
				sel_top = Y_TOP; sel_cnt = Y_CNT;
			end
			default: begin
				sel_c = cz_q; sel_l = z_low_q; sel_h = z_high_q;
				sel_top = Z_TOP; sel_cnt = Z_CNT;
			end
		endcase
	end

	// offsets and magnitudes
	assign num_d = {sel_c[h3ba_pkg::COORD_W-1], sel_c} - {sel_l[h3ba_pkg::COORD_W-1], sel_l};
	assign den_d = {sel_h[h3ba_pkg::COORD_W-1], sel_h} - {sel_l[h3ba_pkg::COORD_W-1], sel_l};
	assign an_d = num_d[h3ba_pkg::COORD_W] ? 33'(-num_d) : 33'(num_d);
	assign ad_d = den_d[h3ba_pkg::COORD_W] ? 33'(-den_d) : 33'(den_d);

	// one restoring division step
	assign dsh_d = NW'({ad_q, 1'b0}) << cmd.step;
	assign ge_d = (n_q >= dsh_d);
	assign quo_d = {quo_q[QW-2:0], ge_d};

	assign status.go_div = !skip_q && (n_q < lim_q);
	assign status.bin_req = req_q[1];
	assign status.clr_last = (clr_q == AW'(DEPTH - 1));

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			cx_q <= coord_x;
			cy_q <= coord_y;
			cz_q <= coord_z;
			energy_q <= energy;
			ix_q <= bin_x;
			iy_q <= bin_y;
			iz_q <= bin_z;
		end
	end

	// bin mapping iterations
	always_ff @(posedge clk) begin
		if (cmd.load) clamp_q <= 1'b0;
		if (cmd.prep) begin
			an_q <= an_d[h3ba_pkg::ABS_W-1:0];
			ad_q <= ad_d[h3ba_pkg::ABS_W-1:0];
			skip_q <= (den_d == '0) || (num_d == '0)
				|| (num_d[h3ba_pkg::COORD_W] != den_d[h3ba_pkg::COORD_W]);
		end
		if (cmd.mul) begin
			n_q <= ((NW'(an_q) * NW'(sel_top)) << 1) + NW'(ad_q);
			lim_q <= (NW'(ad_q) * NW'(sel_cnt)) << 1;
			quo_q <= '0;
		end
		if (cmd.div) begin
			if (ge_d) n_q <= n_q - dsh_d;
			quo_q <= quo_d;
		end
		if (cmd.idx) begin
			if (QW'(ix_q) > X_TOP) begin
				bx_q <= X_TOP; clamp_q <= 1'b1;
			end else begin
				bx_q <= QW'(ix_q);
			end
			if (QW'(iy_q) > Y_TOP) begin
				by_q <= Y_TOP; clamp_q <= 1'b1;
			end else begin
				by_q <= QW'(iy_q);
			end
			if (QW'(iz_q) > Z_TOP) begin
				bz_q <= Z_TOP; clamp_q <= 1'b1;
			end else begin
				bz_q <= QW'(iz_q);
			end
		end
		if (cmd.cmp && !status.go_div) begin
			if (!skip_q) clamp_q <= 1'b1;
			unique case (cmd.axis)
				h3ba_pkg::AXIS_X: bx_q <= skip_q ? '0 : sel_top;
				h3ba_pkg::AXIS_Y: by_q <= skip_q ? '0 : sel_top;
				default: bz_q <= skip_q ? '0 : sel_top;
			endcase
		end
		if (cmd.div && (cmd.step == '0)) begin
			unique case (cmd.axis)
				h3ba_pkg::AXIS_X: bx_q <= quo_d;
				h3ba_pkg::AXIS_Y: by_q <= quo_d;
				default: bz_q <= quo_d;
			endcase
		end
	end

	// linear bin address
	assign addr_d = AW'(32'(bx_q) + 32'(by_q) * 32'(X_BINS) + 32'(bz_q) * 32'(X_BINS * Y_BINS));

	// saturating add
	assign sum_d = {1'b0, rd_q} + (CW+1)'(energy_q);
	assign sat_d = sum_d[CW] ? h3ba_pkg::CONTENT_MAX : sum_d[CW-1:0];

	assign we_d = cmd.clear || (cmd.upd && (req_q == h3ba_pkg::REQ_FILL));
	assign wa_d = cmd.clear ? clr_q : addr_q;
	assign wd_d = cmd.clear ? '0 : sat_d;

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// bin memory
	always_ff @(posedge clk) begin
		if (we_d) mem[wa_d] <= wd_d;
		if (cmd.rd) rd_q <= mem[addr_q];
	end

	// address, result and output word
	always_ff @(posedge clk) begin
		if (cmd.addr) addr_q <= addr_d;
		if (cmd.upd) res_q <= (req_q == h3ba_pkg::REQ_FILL) ? sat_d : rd_q;
		if (cmd.out_load) begin
			content_q <= res_q;
			bxo_q <= bx_q[h3ba_pkg::BIN_W-1:0];
			byo_q <= by_q[h3ba_pkg::BIN_W-1:0];
			bzo_q <= bz_q[h3ba_pkg::BIN_W-1:0];
			clamped_q <= clamp_q;
		end
	end

	assign content = content_q;
	assign bin_x_out = bxo_q;
	assign bin_y_out = byo_q;
	assign bin_z_out = bzo_q;
	assign clamped = clamped_q;

endmodule

>>> sv/histogram_3d_bin_accumulate.sv
// a coordinate request runs, per axis, through prepare, multiply, compare and, for an
// in-range coordinate, the shared restoring divider; then address, read, update, done
// a bin-index request runs through address, read, update, done; done waits for a free
// output register; a finished word waits there while the next request is accepted
// after reset a clearing pass writes every bin to zero, with in_ready low throughout;
// range registers reset to 0.0 and 16.0 on every axis
module histogram_3d_bin_accumulate #(
	parameter int X_BINS = 16,
	parameter int Y_BINS = 16,
	parameter int Z_BINS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [h3ba_pkg::IDX_W-1:0]          cfg_index,
	input  logic [h3ba_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [h3ba_pkg::REQ_W-1:0]          req_type,
	input  logic signed [h3ba_pkg::COORD_W-1:0] coord_x,
	input  logic signed [h3ba_pkg::COORD_W-1:0] coord_y,
	input  logic signed [h3ba_pkg::COORD_W-1:0] coord_z,
	input  logic [h3ba_pkg::ENERGY_W-1:0]       energy,
	input  logic [h3ba_pkg::BIN_W-1:0]          bin_x,
	input  logic [h3ba_pkg::BIN_W-1:0]          bin_y,
	input  logic [h3ba_pkg::BIN_W-1:0]          bin_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [h3ba_pkg::CONTENT_W-1:0]      content,
	output logic [h3ba_pkg::BIN_W-1:0]          bin_x_out,
	output logic [h3ba_pkg::BIN_W-1:0]          bin_y_out,
	output logic [h3ba_pkg::BIN_W-1:0]          bin_z_out,
	output logic                                clamped
);

	h3ba_pkg::cmd_t cmd;
	h3ba_pkg::status_t status;

	// sequencer
	h3ba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// mapping, memory and output register
	h3ba_dp #(
		.X_BINS (X_BINS),
		.Y_BINS (Y_BINS),
		.Z_BINS (Z_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_type  (req_type),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.coord_z   (coord_z),
		.energy    (energy),
		.bin_x     (bin_x),
		.bin_y     (bin_y),
		.bin_z     (bin_z),
		.content   (content),
		.bin_x_out (bin_x_out),
		.bin_y_out (bin_y_out),
		.bin_z_out (bin_z_out),
		.clamped   (clamped)
	);

endmodule
